>>> rtl/container_inode_access_table_core_defines.svh
// Assertion macros for the table's RTL.
`ifndef CONTAINER_INODE_ACCESS_TABLE_CORE_DEFINES_SVH
`define CONTAINER_INODE_ACCESS_TABLE_CORE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define CIA_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("container table check failed");

// The consequent holds in the same cycle as the antecedent.
`define CIA_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("container table check failed");

// The consequent holds in the cycle after the antecedent.
`define CIA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("container table check failed");

`endif

>>> rtl/cia_pkg.sv
package cia_pkg;

   // Field widths of the request and response payloads.
   localparam int REQ_TYPE_W = 3;
   localparam int CID_W      = 3;
   localparam int INODE_W    = 32;
   localparam int STATUS_W   = 2;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_CREATE  = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DESTROY = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_MAP     = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_RECORD  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_FIND    = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_CHECK   = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

   // Per-bank compare results for the slot read in the previous cycle.
   typedef struct packed {
      logic owned;
      logic hidden;
      logic created;
   } match_type;

endpackage

>>> rtl/cia_if.sv
// Request channel.
interface cia_req_if;
   logic                            valid;
   logic                            ready;
   logic [cia_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [cia_pkg::CID_W-1:0]       req_container_id;
   logic [cia_pkg::INODE_W-1:0]     req_inode_number;
   logic [cia_pkg::INODE_W-1:0]     req_mapped_inode;

   modport source (output valid, req_type, req_container_id, req_inode_number,
                   req_mapped_inode, input ready);
   modport sink (input valid, req_type, req_container_id, req_inode_number,
                 req_mapped_inode, output ready);
endinterface

// Response channel.
interface cia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          rsp_answer;
   logic [cia_pkg::STATUS_W-1:0]  rsp_status;

   modport source (output valid, rsp_answer, rsp_status, input ready);
   modport sink (input valid, rsp_answer, rsp_status, output ready);
endinterface

>>> rtl/container_inode_access_table_core.sv
// Create, destroy, map, record, host checks and requests for a container out of range go
// from WORK straight to FINISH; other finds and checks pass through SCAN and DRAIN first.
// A new request is taken only in IDLE, once the response of the last one is loaded; the
// slot scan reads one slot of every container's bank per cycle.
// Reset clears live marks, fill counts and the response valid bit; list memories are
// not swept, since a slot at or above its fill count never matches.
module container_inode_access_table_core #(
   parameter int CONTAINERS   = 8,
   parameter int LIST_ENTRIES = 32,
   parameter int INODE_BITS   = 32
) (
   input logic       clock,
   input logic       reset,
   cia_req_if.sink   req,
   cia_rsp_if.source rsp
);

   localparam int KEEP_W = (INODE_BITS < cia_pkg::INODE_W) ? INODE_BITS : cia_pkg::INODE_W;
   localparam int ADDR_W = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;

   logic [ADDR_W-1:0]                   rd_addr;
   logic [ADDR_W-1:0]                   wr_addr;
   logic [CONTAINERS-1:0]               pair_we;
   logic [CONTAINERS-1:0]               created_we;
   logic [KEEP_W-1:0]                   key;
   logic [KEEP_W-1:0]                   mapped;
   cia_pkg::match_type [CONTAINERS-1:0] match;

   // Sequencer and response register.
   cia_ctrl #(
      .CONTAINERS   (CONTAINERS),
      .LIST_ENTRIES (LIST_ENTRIES),
      .KEEP_W       (KEEP_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .pair_we    (pair_we),
      .created_we (created_we),
      .key        (key),
      .mapped     (mapped),
      .match      (match)
   );

   // One storage bank per container, all scanned in step.
   for (genvar b = 0; b < CONTAINERS; b++) begin : g_bank
      cia_bank #(
         .ENTRIES (LIST_ENTRIES),
         .KEEP_W  (KEEP_W)
      ) u_bank (
         .clock      (clock),
         .rd_addr    (rd_addr),
         .wr_addr    (wr_addr),
         .pair_we    (pair_we[b]),
         .created_we (created_we[b]),
         .wr_mapped  (mapped),
         .key        (key),
         .match      (match[b])
      );
   end

endmodule

>>> rtl/cia_bank.sv
// One container's list storage: owned, hidden and created inodes in three
// synchronous memories sharing a read address, with a compare against the key.
module cia_bank #(
   parameter int ENTRIES = 32,
   parameter int KEEP_W  = 32,
   localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic                pair_we,
   input  logic                created_we,
   input  logic [KEEP_W-1:0]   wr_mapped,
   input  logic [KEEP_W-1:0]   key,
   output cia_pkg::match_type  match
);

   logic [KEEP_W-1:0] owned_mem   [ENTRIES];
   logic [KEEP_W-1:0] hidden_mem  [ENTRIES];
   logic [KEEP_W-1:0] created_mem [ENTRIES];

   logic [KEEP_W-1:0] owned_q_ff;
   logic [KEEP_W-1:0] hidden_q_ff;
   logic [KEEP_W-1:0] created_q_ff;

   // A map request writes an owned/hidden pair at the same slot.
   always_ff @(posedge clock) begin
      if (pair_we) begin
         owned_mem[wr_addr]  <= wr_mapped;
         hidden_mem[wr_addr] <= key;
      end
      if (created_we) begin
         created_mem[wr_addr] <= key;
      end
   end

   // Registered read of one slot from each list.
   always_ff @(posedge clock) begin
      owned_q_ff   <= owned_mem[rd_addr];
      hidden_q_ff  <= hidden_mem[rd_addr];
      created_q_ff <= created_mem[rd_addr];
   end

   // Compare the slot just read with the inode being looked up.
   always_comb begin
      match.owned   = (owned_q_ff == key);
      match.hidden  = (hidden_q_ff == key);
      match.created = (created_q_ff == key);
   end

endmodule

>>> rtl/cia_ctrl.sv
`include "container_inode_access_table_core_defines.svh"

// Request sequencer: live marks, fill counts, list appends, the slot scan
// for find and check requests, and the response register.
module cia_ctrl #(
   parameter int CONTAINERS   = 8,
   parameter int LIST_ENTRIES = 32,
   parameter int KEEP_W       = 32,
   localparam int ADDR_W      = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   cia_req_if.sink                             req,
   cia_rsp_if.source                           rsp,
   output logic [ADDR_W-1:0]                   rd_addr,
   output logic [ADDR_W-1:0]                   wr_addr,
   output logic [CONTAINERS-1:0]               pair_we,
   output logic [CONTAINERS-1:0]               created_we,
   output logic [KEEP_W-1:0]                   key,
   output logic [KEEP_W-1:0]                   mapped,
   input  cia_pkg::match_type [CONTAINERS-1:0] match
);

   localparam int CW     = $clog2(CONTAINERS);
   localparam int FILL_W = $clog2(LIST_ENTRIES + 1);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(LIST_ENTRIES - 1);
   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(LIST_ENTRIES);

   typedef enum logic [2:0] {IDLE, WORK, SCAN, DRAIN, FINISH} state_type;

   state_type                         state_ff, state_in;
   logic [cia_pkg::REQ_TYPE_W-1:0]    type_ff, type_in;
   logic [CW-1:0]                     cid_ff, cid_in;
   logic                              range_ff, range_in;
   logic [KEEP_W-1:0]                 key_ff, key_in;
   logic [KEEP_W-1:0]                 mapped_ff, mapped_in;
   logic [CONTAINERS-1:0]             live_ff, live_in;
   logic [FILL_W-1:0]                 pair_fill_ff [CONTAINERS];
   logic [FILL_W-1:0]                 pair_fill_in [CONTAINERS];
   logic [FILL_W-1:0]                 created_fill_ff [CONTAINERS];
   logic [FILL_W-1:0]                 created_fill_in [CONTAINERS];
   logic [ADDR_W-1:0]                 scan_addr_ff, scan_addr_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0]                 cmp_addr_ff, cmp_addr_in;
   logic                              hid_ff, hid_in;
   logic                              own_ff, own_in;
   logic                              other_ff, other_in;
   logic                              found_ff, found_in;
   logic [cia_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_answer_ff, rsp_answer_in;
   logic [cia_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic [6:0]                        cid_wide;
   logic                              hid_now, own_now, other_now, found_now;
   logic                              final_answer;

   assign req.ready  = (state_ff == IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.rsp_answer = rsp_answer_ff;
   assign rsp.rsp_status = rsp_status_ff;
   assign rd_addr    = scan_addr_ff;
   assign key        = key_ff;
   assign mapped     = mapped_ff;
   assign cid_wide   = 7'(req.req_container_id);

   // Hits in the slot read last cycle; a slot counts only below its fill.
   always_comb begin
      logic self;
      logic pair_ok;
      logic created_ok;
      hid_now   = 1'b0;
      own_now   = 1'b0;
      other_now = 1'b0;
      found_now = 1'b0;
      for (int b = 0; b < CONTAINERS; b++) begin
         self       = (CW'(b) == cid_ff);
         pair_ok    = (FILL_W'(cmp_addr_ff) < pair_fill_ff[b]);
         created_ok = (FILL_W'(cmp_addr_ff) < created_fill_ff[b]);
         hid_now   = hid_now   | (self & pair_ok & match[b].hidden);
         own_now   = own_now   | (self & pair_ok & match[b].owned);
         found_now = found_now | (self & created_ok & match[b].created);
         other_now = other_now | (~self & live_ff[b] & pair_ok & match[b].owned);
      end
   end

   // Answer from the scan flags once the last slot has been compared; a host check answers 1.
   always_comb begin
      case (type_ff)
         cia_pkg::REQ_CHECK: begin
            if (range_ff && cid_ff == '0) begin
               final_answer = 1'b1;
            end else begin
               final_answer = range_ff & ~hid_ff & (own_ff | ~other_ff);
            end
         end
         cia_pkg::REQ_FIND: final_answer = range_ff & found_ff;
         default:           final_answer = 1'b0;
      endcase
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in        = state_ff;
      type_in         = type_ff;
      cid_in          = cid_ff;
      range_in        = range_ff;
      key_in          = key_ff;
      mapped_in       = mapped_ff;
      live_in         = live_ff;
      pair_fill_in    = pair_fill_ff;
      created_fill_in = created_fill_ff;
      scan_addr_in    = scan_addr_ff;
      hid_in          = hid_ff;
      own_in          = own_ff;
      other_in        = other_ff;
      found_in        = found_ff;
      status_in       = status_ff;
      rsp_answer_in   = rsp_answer_ff;
      rsp_status_in   = rsp_status_ff;
      pair_we         = '0;
      created_we      = '0;
      wr_addr         = '0;
      cmp_valid_in    = (state_ff == SCAN);
      cmp_addr_in     = scan_addr_ff;

      // The response register empties when its response is taken.
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;

      // Fold in the compare of the slot read in the previous cycle.
      if (cmp_valid_ff) begin
         hid_in   = hid_ff | hid_now;
         own_in   = own_ff | own_now;
         other_in = other_ff | other_now;
         found_in = found_ff | found_now;
      end

      case (state_ff)
         IDLE: begin
            if (req.valid) begin
               type_in   = req.req_type;
               cid_in    = cid_wide[CW-1:0];
               range_in  = (cid_wide < 7'(CONTAINERS));
               key_in    = req.req_inode_number[KEEP_W-1:0];
               mapped_in = req.req_mapped_inode[KEEP_W-1:0];
               state_in  = WORK;
            end
         end
         WORK: begin
            hid_in       = 1'b0;
            own_in       = 1'b0;
            other_in     = 1'b0;
            found_in     = 1'b0;
            status_in    = cia_pkg::STATUS_OK;
            scan_addr_in = '0;
            state_in     = FINISH;
            case (type_ff)
               cia_pkg::REQ_CREATE: begin
                  if (range_ff) begin
                     pair_fill_in[cid_ff]    = '0;
                     created_fill_in[cid_ff] = '0;
                     live_in[cid_ff]         = (cid_ff != '0);
                  end
               end
               cia_pkg::REQ_DESTROY: begin
                  if (!range_ff || !live_ff[cid_ff]) begin
                     status_in = cia_pkg::STATUS_ABSENT;
                  end
                  if (range_ff) begin
                     live_in[cid_ff] = 1'b0;
                  end
               end
               cia_pkg::REQ_MAP: begin
                  if (range_ff) begin
                     wr_addr = pair_fill_ff[cid_ff][ADDR_W-1:0];
                     if (pair_fill_ff[cid_ff] >= FILL_MAX) begin
                        status_in = cia_pkg::STATUS_FULL;
                     end else begin
                        pair_we[cid_ff]      = 1'b1;
                        pair_fill_in[cid_ff] = pair_fill_ff[cid_ff] + 1'b1;
                     end
                  end
               end
               cia_pkg::REQ_RECORD: begin
                  if (range_ff) begin
                     wr_addr = created_fill_ff[cid_ff][ADDR_W-1:0];
                     if (created_fill_ff[cid_ff] >= FILL_MAX) begin
                        status_in = cia_pkg::STATUS_FULL;
                     end else begin
                        created_we[cid_ff]      = 1'b1;
                        created_fill_in[cid_ff] = created_fill_ff[cid_ff] + 1'b1;
                     end
                  end
               end
               cia_pkg::REQ_FIND: begin
                  if (range_ff) begin
                     state_in = SCAN;
                  end
               end
               cia_pkg::REQ_CHECK: begin
                  if (range_ff && cid_ff != '0) begin
                     state_in = SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         SCAN: begin
            // One slot of every bank is read per cycle.
            if (scan_addr_ff == LAST_SLOT) begin
               state_in = DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + 1'b1;
            end
         end
         DRAIN: begin
            state_in = FINISH;
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = final_answer;
               rsp_status_in = status_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         live_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CONTAINERS; c++) begin
            pair_fill_ff[c]    <= '0;
            created_fill_ff[c] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         live_ff         <= live_in;
         cmp_valid_ff    <= cmp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pair_fill_ff    <= pair_fill_in;
         created_fill_ff <= created_fill_in;
      end
      type_ff       <= type_in;
      cid_ff        <= cid_in;
      range_ff      <= range_in;
      key_ff        <= key_in;
      mapped_ff     <= mapped_in;
      scan_addr_ff  <= scan_addr_in;
      cmp_addr_ff   <= cmp_addr_in;
      hid_ff        <= hid_in;
      own_ff        <= own_in;
      other_ff      <= other_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   `CIA_ASSERT_ALWAYS(a_host_never_live, !live_ff[0])
   `CIA_ASSERT_ALWAYS(a_single_list_write, $onehot0({pair_we, created_we}))
   `CIA_ASSERT_NEXT(a_accept_starts_work, req.valid && req.ready, state_ff == WORK)
   `CIA_ASSERT_IMPLY(a_rsp_loaded_at_finish, $rose(rsp_valid_ff), $past(state_ff) == FINISH)
   `CIA_ASSERT_IMPLY(a_fill_bounded, state_ff == FINISH && range_ff, pair_fill_ff[cid_ff] <= FILL_MAX && created_fill_ff[cid_ff] <= FILL_MAX)

endmodule
